// File: rtl/core/cse_pkg.sv
// shared widths, payload structs and controller/datapath interface types
`timescale 1ns / 1ps

package cse_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int DOT_W     = 42;
	localparam int SQ_W      = 41;
	localparam int RAD_SHIFT = 22;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int DEN_W     = 2 * ROOT_W;
	localparam int QUO_W     = 38;
	localparam int SIM_W     = 16;
	localparam int CNT_W     = 6;

	localparam logic [SIM_W-1:0] ONE_Q14 = 16'd16384;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a_value;
		logic signed [SAMPLE_W-1:0] b_value;
		logic                       last_element;
	} pair_t;

	typedef struct packed {
		logic signed [SIM_W-1:0] similarity;
		logic                    zero_norm;
	} result_t;

	typedef struct packed {
		logic capture;
		logic acc_clear;
		logic check;
		logic root_load;
		logic root_sel_b;
		logic root_step;
		logic root_store_a;
		logic root_store_b;
		logic den_load;
		logic div_step;
		logic div_first;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_norm;
	} dp_status_t;

endpackage

// File: rtl/core/cse_datapath.sv
// accumulators, shared square root unit, multiplier, divider and result register
`timescale 1ns / 1ps

module cse_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cse_pkg::pair_t       pair,
	input  cse_pkg::dp_cmd_t     cmd,
	output cse_pkg::dp_status_t  status,
	output cse_pkg::result_t     result
);

	localparam int DW = cse_pkg::DOT_W;
	localparam int SW = cse_pkg::SQ_W;
	localparam int PW = cse_pkg::PROD_W;
	localparam int RW = cse_pkg::ROOT_W;
	localparam int NW = cse_pkg::DEN_W;
	localparam int QW = cse_pkg::QUO_W;
	localparam int MW = cse_pkg::SIM_W;

	// product stage
	logic signed [PW-1:0] prod_ab_w;
	logic signed [PW-1:0] prod_aa_w;
	logic signed [PW-1:0] prod_bb_w;
	logic signed [PW-1:0] prod_ab_s1;
	logic [PW-2:0]        prod_aa_s1;
	logic [PW-2:0]        prod_bb_s1;
	logic                 valid_s1;

	assign prod_ab_w = pair.a_value * pair.b_value;
	assign prod_aa_w = pair.a_value * pair.a_value;
	assign prod_bb_w = pair.b_value * pair.b_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.capture;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_ab_s1 <= prod_ab_w;
			prod_aa_s1 <= prod_aa_w[PW-2:0];
			prod_bb_s1 <= prod_bb_w[PW-2:0];
		end
	end

	// saturating accumulators
	logic signed [DW-1:0] dot_q;
	logic [SW-1:0]        sqa_q;
	logic [SW-1:0]        sqb_q;
	logic signed [DW:0]   dot_add;
	logic [SW:0]          sqa_add;
	logic [SW:0]          sqb_add;
	logic signed [DW-1:0] dot_sat;
	logic [SW-1:0]        sqa_sat;
	logic [SW-1:0]        sqb_sat;

	assign dot_add = {dot_q[DW-1], dot_q} + {{(DW+1-PW){prod_ab_s1[PW-1]}}, prod_ab_s1};
	assign sqa_add = {1'b0, sqa_q} + {{(SW+2-PW){1'b0}}, prod_aa_s1};
	assign sqb_add = {1'b0, sqb_q} + {{(SW+2-PW){1'b0}}, prod_bb_s1};

	always_comb begin
		if (dot_add[DW] != dot_add[DW-1]) begin
			dot_sat = dot_add[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			dot_sat = dot_add[DW-1:0];
		end
		sqa_sat = sqa_add[SW] ? {SW{1'b1}} : sqa_add[SW-1:0];
		sqb_sat = sqb_add[SW] ? {SW{1'b1}} : sqb_add[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			sqa_q <= '0;
			sqb_q <= '0;
		end else if (cmd.acc_clear) begin
			dot_q <= '0;
			sqa_q <= '0;
			sqb_q <= '0;
		end else if (valid_s1) begin
			dot_q <= dot_sat;
			sqa_q <= sqa_sat;
			sqb_q <= sqb_sat;
		end
	end

	assign status.zero_norm = (sqa_q == '0) || (sqb_q == '0);

	logic zero_q;
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			zero_q <= status.zero_norm;
		end
	end

	// square root, two radicand bits per step
	logic [cse_pkg::RAD_W-1:0] rad_q;
	logic [RW+1:0]             rem_r_q;
	logic [RW-1:0]             root_q;
	logic [RW+3:0]             rem_sh;
	logic [RW+3:0]             root_trial;
	logic                      root_ge;
	logic [RW+3:0]             rem_r_diff;
	logic [RW-1:0]             root_next;
	logic [RW-1:0]             na_q;
	logic [RW-1:0]             nb_q;
	logic [SW-1:0]             rad_src;

	assign rad_src    = cmd.root_sel_b ? sqb_q : sqa_q;
	assign rem_sh     = {rem_r_q, rad_q[cse_pkg::RAD_W-1 -: 2]};
	assign root_trial = {2'b00, root_q, 2'b01};
	assign root_ge    = rem_sh >= root_trial;
	assign rem_r_diff = root_ge ? (rem_sh - root_trial) : rem_sh;
	assign root_next  = {root_q[RW-2:0], root_ge};

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rad_q   <= {{(cse_pkg::RAD_W-SW-cse_pkg::RAD_SHIFT){1'b0}}, rad_src,
				{cse_pkg::RAD_SHIFT{1'b0}}};
			rem_r_q <= '0;
			root_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q   <= {rad_q[cse_pkg::RAD_W-3:0], 2'b00};
			rem_r_q <= rem_r_diff[RW+1:0];
			root_q  <= root_next;
		end
		if (cmd.root_store_a) begin
			na_q <= root_next;
		end
		if (cmd.root_store_b) begin
			nb_q <= root_next;
		end
	end

	// denominator
	logic [NW-1:0] den_q;
	always_ff @(posedge clk) begin
		if (cmd.den_load) begin
			den_q <= na_q * nb_q;
		end
	end

	// restoring divide of |dot| by den, one quotient bit per step
	logic          neg_w;
	logic [DW-1:0] mag_w;
	logic [NW-1:0] div_trial;
	logic          div_ge;
	logic [NW-1:0] div_diff;
	logic [NW-2:0] rem_d_q;
	logic [QW-1:0] quo_q;
	logic          clamp_q;

	assign neg_w     = dot_q[DW-1];
	assign mag_w     = neg_w ? (-dot_q) : dot_q;
	assign div_trial = cmd.div_first ? {{(NW-DW){1'b0}}, mag_w} : {rem_d_q, 1'b0};
	assign div_ge    = div_trial >= den_q;
	assign div_diff  = div_ge ? (div_trial - den_q) : div_trial;

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			rem_d_q <= div_diff[NW-2:0];
			quo_q   <= {quo_q[QW-2:0], div_ge};
			if (cmd.div_first) begin
				clamp_q <= {{(NW+1-DW){1'b0}}, mag_w} >= {den_q, 1'b0};
			end
		end
	end

	// round half up, clamp, sign
	logic [QW:0]             quo_inc;
	logic [QW-1:0]           quo_rnd;
	logic [MW-1:0]           mag_res;
	logic signed [MW-1:0]    sim_w;
	cse_pkg::result_t        result_q;

	assign quo_inc = {1'b0, quo_q} + {{QW{1'b0}}, 1'b1};
	assign quo_rnd = quo_inc[QW:1];

	always_comb begin
		if (clamp_q || (quo_rnd > {{(QW-MW){1'b0}}, cse_pkg::ONE_Q14})) begin
			mag_res = cse_pkg::ONE_Q14;
		end else begin
			mag_res = quo_rnd[MW-1:0];
		end
		if (zero_q) begin
			sim_w = '0;
		end else if (neg_w) begin
			sim_w = -$signed(mag_res);
		end else begin
			sim_w = $signed(mag_res);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			result_q.similarity <= sim_w;
			result_q.zero_norm  <= zero_q;
		end
	end

	assign result = result_q;

endmodule

// File: rtl/core/cse_ctrl.sv
// sequencing state machine and output valid
`timescale 1ns / 1ps

module cse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	input  logic                 pair_last,
	output logic                 pair_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  cse_pkg::dp_status_t  status,
	output cse_pkg::dp_cmd_t     cmd
);

	typedef enum logic [8:0] {
		S_ACC    = 9'b000000001,
		S_FLUSH  = 9'b000000010,
		S_CHECK  = 9'b000000100,
		S_ROOT_A = 9'b000001000,
		S_LOAD_B = 9'b000010000,
		S_ROOT_B = 9'b000100000,
		S_MUL    = 9'b001000000,
		S_DIV    = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t                    state_q;
	state_t                    state_d;
	logic [cse_pkg::CNT_W-1:0] cnt_q;
	logic [cse_pkg::CNT_W-1:0] cnt_d;
	logic                      result_valid_q;
	logic                      accept;
	logic                      slot_free;
	logic                      root_last;
	logic                      div_last;

	assign pair_stall = (state_q != S_ACC);
	assign accept     = pair_valid && !pair_stall;
	assign slot_free  = !result_valid_q || !result_stall;
	assign root_last  = (cnt_q == cse_pkg::CNT_W'(cse_pkg::ROOT_W - 1));
	assign div_last   = (cnt_q == cse_pkg::CNT_W'(cse_pkg::QUO_W - 1));

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.capture = accept;
		case (state_q)
			S_ACC: begin
				if (accept && pair_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// last pair is summed this cycle
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				cnt_d     = '0;
				if (status.zero_norm) begin
					state_d = S_DONE;
				end else begin
					cmd.root_load = 1'b1;
					state_d       = S_ROOT_A;
				end
			end
			S_ROOT_A: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (root_last) begin
					cmd.root_store_a = 1'b1;
					state_d          = S_LOAD_B;
				end
			end
			S_LOAD_B: begin
				cmd.root_load  = 1'b1;
				cmd.root_sel_b = 1'b1;
				cnt_d          = '0;
				state_d        = S_ROOT_B;
			end
			S_ROOT_B: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (root_last) begin
					cmd.root_store_b = 1'b1;
					state_d          = S_MUL;
				end
			end
			S_MUL: begin
				cmd.den_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				cnt_d         = cnt_q + 1'b1;
				if (div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the output register to free up, then clear sums
				if (slot_free) begin
					cmd.res_load  = 1'b1;
					cmd.acc_clear = 1'b1;
					state_d       = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_ACC;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

// File: rtl/core/cosine_similarity_engine.sv
// cosine similarity engine top level
`timescale 1ns / 1ps

// Streaming cosine similarity of two vectors of signed Q4.12 elements.
// Input channel pair/pair_valid/pair_stall: one element pair per transfer,
// last_element marks the final pair of a vector. Pairs are taken one per
// cycle while the engine accumulates the dot product and both sums of
// squares (products are registered, then summed with saturation).
// After the last pair the input is stalled while the result is computed:
// a flush step, a zero check, two square roots in turn on one shared
// root unit, a multiply and a restoring divide, after which the result
// register loads as soon as it is free. If either sum of squares is zero
// the zero check goes straight to the result load, with similarity 0
// and zero_norm set.
// Output channel result/result_valid/result_stall: one Q1.14 similarity per
// vector. The result sits in an output register; while the receiver stalls
// the engine keeps taking pairs of the next vector and only waits at the
// end of that vector's computation if the register is still full.
// Sums are cleared when a result is loaded. Reset (arst_n low) clears the
// sums, the state machine and result_valid.

module cosine_similarity_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pair_valid,
	output logic              pair_stall,
	input  cse_pkg::pair_t    pair,
	output logic              result_valid,
	input  logic              result_stall,
	output cse_pkg::result_t  result
);

	cse_pkg::dp_cmd_t    cmd;
	cse_pkg::dp_status_t status;

	cse_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair_valid   (pair_valid),
		.pair_last    (pair.last_element),
		.pair_stall   (pair_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	cse_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	// a last pair transfer always stalls the input for the computation
	assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_stall && pair.last_element |=> pair_stall)
	else $error("input not stalled after last pair");

	// zero norm results carry similarity zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_norm |-> result.similarity == 16'sd0)
	else $error("zero norm result with nonzero similarity");

	// similarity clamped to plus or minus one
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.similarity <= 16'sd16384)
			&& (result.similarity >= -16'sd16384))
	else $error("similarity out of range");

	// a new result is only loaded while the input side is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> pair_stall)
	else $error("result loaded while accepting pairs");

endmodule
